// ===== hdl/avr_pkg.sv =====
// Shared types, constants and tables for the axis vector rotator.
// No dependencies; every other file in hdl/ imports this package.
package avr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    // CORDIC datapath width: Q2.30 plus headroom for growth and sign
    localparam int CW = 34;
    // product of a CORDIC value and a Q7.8 component, and the sum of two of them
    localparam int PW = CW + 16;
    localparam int SW = PW + 1;
    localparam int FRAC_SHIFT = 30;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'sd536870912);

    // angle handling: 1/64 degree steps, 2^32 binary units per turn
    localparam int FULL_TURN   = 23040;
    localparam int ANG_W       = 15;
    localparam int DEG_GROUP   = 45;
    localparam int Q_W         = 9;
    localparam int GROUP_SHIFT = 23;
    localparam int RECIP_SHIFT = 29;
    localparam int PROD_W      = ANG_W + 24;
    localparam logic [23:0] RECIP_45 = 24'd11930465;
    localparam int IDX_W       = 6;

    localparam int PREP_LAT = 3;
    localparam int OUT_LAT  = 3;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic [7:0] CH_X_LO = "x";
    localparam logic [7:0] CH_X_UP = "X";
    localparam logic [7:0] CH_Y_LO = "y";
    localparam logic [7:0] CH_Y_UP = "Y";
    localparam logic [7:0] CH_Z_LO = "z";
    localparam logic [7:0] CH_Z_UP = "Z";

    typedef logic signed [CW-1:0] t_atan_tbl [ATAN_ENTRIES];

    localparam t_atan_tbl ATAN_TBL = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    // binary angle of r * 64/45 degree-steps groups, rounded: (r*2^23 + 22) / 45
    typedef logic [GROUP_SHIFT-1:0] t_frac_tbl [2**IDX_W];

    function automatic t_frac_tbl f_frac_tbl();
        t_frac_tbl tbl;
        longint    v;
        for (int i = 0; i < 2**IDX_W; i++) begin
            if (i < DEG_GROUP) begin
                v = (longint'(i) * (longint'(1) << GROUP_SHIFT) + 64'sd22) / 45;
                tbl[i] = GROUP_SHIFT'(v);
            end else begin
                tbl[i] = '0;
            end
        end
        return tbl;
    endfunction

    localparam t_frac_tbl FRAC_TBL = f_frac_tbl();

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cvec;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic [1:0]         sel;
        logic               flip;
    } t_side;

endpackage

// ===== hdl/avr_angle_prep.sv =====
// Angle front end: wrap to one turn, convert to binary angle, fold to +-90 degrees.
// Also decodes the axis letter. Depends on avr_pkg.
module avr_angle_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [15:0] i_vec_x,
    input  logic signed [15:0] i_vec_y,
    input  logic signed [15:0] i_vec_z,
    input  logic [7:0]         i_axis_char,
    input  logic signed [15:0] i_angle_deg,
    output logic               o_vld,
    output avr_pkg::t_cvec     o_vec,
    output avr_pkg::t_side     o_side
);
    import avr_pkg::*;

    localparam logic signed [16:0] TURN1 = 17'(FULL_TURN);
    localparam logic signed [16:0] TURN2 = 17'(2 * FULL_TURN);

    // stage 1: wrap and decode
    logic signed [16:0] s_ang;
    logic signed [16:0] s_wrap;
    t_side              n1_side;
    logic               r1_vld;
    logic [ANG_W-1:0]   r1_ang;
    t_side              r1_side;

    always_comb begin
        s_ang = 17'(i_angle_deg);
        if (s_ang < -TURN1) begin
            s_wrap = s_ang + TURN2;
        end else if (s_ang < 17'sd0) begin
            s_wrap = s_ang + TURN1;
        end else if (s_ang >= TURN1) begin
            s_wrap = s_ang - TURN1;
        end else begin
            s_wrap = s_ang;
        end
        n1_side.vx   = i_vec_x;
        n1_side.vy   = i_vec_y;
        n1_side.vz   = i_vec_z;
        n1_side.flip = 1'b0;
        if (i_axis_char inside {CH_X_LO, CH_X_UP}) begin
            n1_side.sel = AXIS_X;
        end else if (i_axis_char inside {CH_Y_LO, CH_Y_UP}) begin
            n1_side.sel = AXIS_Y;
        end else if (i_axis_char inside {CH_Z_LO, CH_Z_UP}) begin
            n1_side.sel = AXIS_Z;
        end else begin
            n1_side.sel = AXIS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_ang  <= s_wrap[ANG_W-1:0];
        r1_side <= n1_side;
    end

    // stage 2: quotient by 45 through a reciprocal multiply
    logic               r2_vld;
    logic [PROD_W-1:0]  r2_prod;
    logic [ANG_W-1:0]   r2_ang;
    t_side              r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_prod <= PROD_W'(r1_ang) * PROD_W'(RECIP_45);
        r2_ang  <= r1_ang;
        r2_side <= r1_side;
    end

    // stage 3: whole groups plus table for the remainder, then fold
    logic [Q_W-1:0]   s_q;
    logic [ANG_W-1:0] s_rem;
    logic [31:0]      s_units;
    logic             s_flip;
    logic [31:0]      s_folded;
    t_cvec            n3_vec;
    t_side            n3_side;

    always_comb begin
        s_q      = r2_prod[RECIP_SHIFT +: Q_W];
        s_rem    = r2_ang - ANG_W'(ANG_W'(s_q) * ANG_W'(DEG_GROUP));
        s_units  = {s_q, {GROUP_SHIFT{1'b0}}} + 32'(FRAC_TBL[s_rem[IDX_W-1:0]]);
        // adding a quarter turn sets the top bit exactly when these differ
        s_flip   = s_units[31] ^ s_units[30];
        s_folded = {s_units[31] ^ s_flip, s_units[30:0]};
        n3_vec.x = GAIN_Q30;
        n3_vec.y = '0;
        n3_vec.z = {{(CW-32){s_folded[31]}}, s_folded};
        n3_side  = r2_side;
        n3_side.flip = s_flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r2_vld;
        end
        o_vec  <= n3_vec;
        o_side <= n3_side;
    end

endmodule

// ===== hdl/avr_cordic_stage.sv =====
// One rotation-mode CORDIC micro-rotation, registered.
// Depends on avr_pkg for the datapath width and arctangent table.
module avr_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  avr_pkg::t_cvec i_vec,
    input  avr_pkg::t_side i_side,
    output logic           o_vld,
    output avr_pkg::t_cvec o_vec,
    output avr_pkg::t_side o_side
);
    import avr_pkg::*;

    logic signed [CW-1:0] s_dx;
    logic signed [CW-1:0] s_dy;
    t_cvec                n_vec;

    always_comb begin
        s_dx = i_vec.y >>> STEP;
        s_dy = i_vec.x >>> STEP;
        // residual angle sign picks the direction
        if (!i_vec.z[CW-1]) begin
            n_vec.x = i_vec.x - s_dx;
            n_vec.y = i_vec.y + s_dy;
            n_vec.z = i_vec.z - ATAN_TBL[STEP];
        end else begin
            n_vec.x = i_vec.x + s_dx;
            n_vec.y = i_vec.y - s_dy;
            n_vec.z = i_vec.z + ATAN_TBL[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_vec  <= n_vec;
        o_side <= i_side;
    end

endmodule

// ===== hdl/avr_rotate_out.sv =====
// Output back end: four products, signed sums with rounding, saturation and routing.
// Depends on avr_pkg.
module avr_rotate_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  avr_pkg::t_cvec     i_cs,
    input  avr_pkg::t_side     i_side,
    output logic               o_valid,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic               o_axis_error
);
    import avr_pkg::*;

    localparam int RW = SW - FRAC_SHIFT;

    function automatic logic signed [15:0] f_sat(input logic signed [RW-1:0] v);
        logic signed [15:0] res;
        if (v > RW'(32767)) begin
            res = 16'sh7fff;
        end else if (v < -RW'(32768)) begin
            res = -16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // stage P: pick the pair in the rotation plane and multiply
    logic signed [15:0]   s_p;
    logic signed [15:0]   s_q;
    logic                 rp_vld;
    logic signed [PW-1:0] rp_cp;
    logic signed [PW-1:0] rp_sq;
    logic signed [PW-1:0] rp_sp;
    logic signed [PW-1:0] rp_cq;
    t_side                rp_side;

    always_comb begin
        case (i_side.sel)
            AXIS_X: begin
                s_p = i_side.vy;
                s_q = i_side.vz;
            end
            AXIS_Y: begin
                s_p = i_side.vz;
                s_q = i_side.vx;
            end
            default: begin
                s_p = i_side.vx;
                s_q = i_side.vy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_vld <= 1'b0;
        end else begin
            rp_vld <= i_vld;
        end
        rp_cp   <= PW'(i_cs.x) * PW'(s_p);
        rp_sq   <= PW'(i_cs.y) * PW'(s_q);
        rp_sp   <= PW'(i_cs.y) * PW'(s_p);
        rp_cq   <= PW'(i_cs.x) * PW'(s_q);
        rp_side <= i_side;
    end

    // stage S: sums, negated when the angle was folded by half a turn
    logic                 rs_vld;
    logic signed [SW-1:0] rs_a;
    logic signed [SW-1:0] rs_b;
    t_side                rs_side;
    logic signed [SW-1:0] n_a;
    logic signed [SW-1:0] n_b;

    always_comb begin
        if (rp_side.flip) begin
            n_a = SW'(rp_sq) - SW'(rp_cp) + ROUND_HALF;
            n_b = ROUND_HALF - SW'(rp_sp) - SW'(rp_cq);
        end else begin
            n_a = SW'(rp_cp) - SW'(rp_sq) + ROUND_HALF;
            n_b = SW'(rp_sp) + SW'(rp_cq) + ROUND_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rs_vld <= 1'b0;
        end else begin
            rs_vld <= rp_vld;
        end
        rs_a    <= n_a;
        rs_b    <= n_b;
        rs_side <= rp_side;
    end

    // stage O: scale down, clamp, route back to the components
    logic signed [15:0] s_ra;
    logic signed [15:0] s_rb;
    logic signed [15:0] n_x;
    logic signed [15:0] n_y;
    logic signed [15:0] n_z;
    logic               n_err;

    always_comb begin
        s_ra  = f_sat(rs_a[SW-1:FRAC_SHIFT]);
        s_rb  = f_sat(rs_b[SW-1:FRAC_SHIFT]);
        n_x   = rs_side.vx;
        n_y   = rs_side.vy;
        n_z   = rs_side.vz;
        n_err = 1'b0;
        case (rs_side.sel)
            AXIS_X: begin
                n_y = s_ra;
                n_z = s_rb;
            end
            AXIS_Y: begin
                n_z = s_ra;
                n_x = s_rb;
            end
            AXIS_Z: begin
                n_x = s_ra;
                n_y = s_rb;
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= rs_vld;
        end
        o_out_x      <= n_x;
        o_out_y      <= n_y;
        o_out_z      <= n_z;
        o_axis_error <= n_err;
    end

endmodule

// ===== hdl/axis_vector_rotator_top.sv =====
// Pipeline: three angle front-end stages, one stage per CORDIC micro-rotation,
// three output stages.
// Throughput: one request per cycle; busy is tied low and the pipeline never stalls.
// Results appear for one cycle each and must be taken; the receiver cannot hold them.
// Synchronous active-low reset clears the valid bits only; data registers are not reset.
// Top level of the axis vector rotator. Depends on avr_pkg and the avr_* modules.
module axis_vector_rotator_top #(
    parameter int CORDIC_STEPS = avr_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_vec_x,
    input  logic signed [15:0] i_vec_y,
    input  logic signed [15:0] i_vec_z,
    input  logic [7:0]         i_axis_char,
    input  logic signed [15:0] i_angle_deg,
    output logic               o_valid,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic               o_axis_error
);
    import avr_pkg::*;

    localparam int LAT = PREP_LAT + CORDIC_STEPS + OUT_LAT;

    logic [CORDIC_STEPS:0] g_vld;
    t_cvec                 g_vec  [CORDIC_STEPS+1];
    t_side                 g_side [CORDIC_STEPS+1];

    assign busy = 1'b0;

    avr_angle_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (start & ~busy),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_axis_char (i_axis_char),
        .i_angle_deg (i_angle_deg),
        .o_vld       (g_vld[0]),
        .o_vec       (g_vec[0]),
        .o_side      (g_side[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        avr_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (g_vld[i]),
            .i_vec   (g_vec[i]),
            .i_side  (g_side[i]),
            .o_vld   (g_vld[i+1]),
            .o_vec   (g_vec[i+1]),
            .o_side  (g_side[i+1])
        );
    end

    avr_rotate_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (g_vld[CORDIC_STEPS]),
        .i_cs         (g_vec[CORDIC_STEPS]),
        .i_side       (g_side[CORDIC_STEPS]),
        .o_valid      (o_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_axis_error (o_axis_error)
    );

    // every result traces back to an earlier request on start
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without a matching request");

    a_error_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_axis_error == !($past(i_axis_char, LAT) == CH_X_LO ||
                                       $past(i_axis_char, LAT) == CH_X_UP ||
                                       $past(i_axis_char, LAT) == CH_Y_LO ||
                                       $past(i_axis_char, LAT) == CH_Y_UP ||
                                       $past(i_axis_char, LAT) == CH_Z_LO ||
                                       $past(i_axis_char, LAT) == CH_Z_UP)))
        else $error("axis error flag does not match the requested letter");

    a_error_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_axis_error) |-> (o_out_x == $past(i_vec_x, LAT) &&
                                       o_out_y == $past(i_vec_y, LAT) &&
                                       o_out_z == $past(i_vec_z, LAT)))
        else $error("unknown axis did not pass the vector through");

endmodule

// ===== tb/axis_vector_rotator_top_tb.sv =====
// Self-checking testbench for axis_vector_rotator_top: directed and random requests,
// each checked against a CORDIC rotation predictor held in a small scoreboard class.
// Depends on avr_pkg and the RTL of axis_vector_rotator_top; reads no files.
module axis_vector_rotator_top_tb;
    import avr_pkg::*;

    localparam int      STEPS        = CORDIC_STEPS_DEF;
    localparam int      PIPE_LAT     = STEPS + 6;
    localparam int      TURN_STEPS   = 23040;
    localparam longint  CORDIC_GAIN  = 64'sd652032874;
    localparam longint  HALF_LSB_Q30 = 64'sd536870912;
    localparam int      CYCLE_LIMIT  = 200000;
    localparam int      N_RANDOM     = 950;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic [7:0]         axis;
        logic signed [15:0] angle;
    } t_rot_req;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               axis_err;
    } t_rot_res;

    class rotation_checker;
        t_rot_res rotated_vectors[$];
        int       n_checked;
        int       n_errors;
        int       n_bad_axis;

        // binary-angle arctangent table, 2^32 per turn
        longint   atan_bam[24] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215,
            2608, 1304, 652, 326, 163, 81
        };

        function automatic logic signed [15:0] round_to_q78(longint acc);
            longint r;
            r = (acc + HALF_LSB_Q30) >>> 30;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return 16'(r);
        endfunction

        function automatic t_rot_res rotate_vector(t_rot_req r);
            longint    a, x, y, z, dx, dy, vx, vy, vz;
            bit [31:0] units;
            bit [31:0] shifted;
            bit        flip;
            int        n;
            t_rot_res  res;
            a = longint'(r.angle) % TURN_STEPS;
            if (a < 0) a += TURN_STEPS;
            units = 32'(((a << 26) + 180) / 360);
            shifted = units + 32'h4000_0000;
            flip = shifted[31];
            // fold into [-90, 90) degrees; undo by negating afterwards
            if (flip) units = units - 32'h8000_0000;
            z = longint'(signed'(units));
            x = CORDIC_GAIN;
            y = 0;
            n = (STEPS > 24) ? 24 : STEPS;
            for (int i = 0; i < n; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_bam[i];
                end else begin
                    x += dx; y -= dy; z += atan_bam[i];
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            vx = longint'(r.vx);
            vy = longint'(r.vy);
            vz = longint'(r.vz);
            res.x = r.vx;
            res.y = r.vy;
            res.z = r.vz;
            res.axis_err = 1'b0;
            if (r.axis == CH_X_LO || r.axis == CH_X_UP) begin
                res.y = round_to_q78(x * vy - y * vz);
                res.z = round_to_q78(y * vy + x * vz);
            end else if (r.axis == CH_Y_LO || r.axis == CH_Y_UP) begin
                res.x = round_to_q78(x * vx + y * vz);
                res.z = round_to_q78(x * vz - y * vx);
            end else if (r.axis == CH_Z_LO || r.axis == CH_Z_UP) begin
                res.x = round_to_q78(x * vx - y * vy);
                res.y = round_to_q78(y * vx + x * vy);
            end else begin
                res.axis_err = 1'b1;
            end
            return res;
        endfunction

        function void note_request(t_rot_req r);
            t_rot_res e;
            e = rotate_vector(r);
            if (e.axis_err) n_bad_axis++;
            rotated_vectors.push_back(e);
        endfunction

        function void check_result(t_rot_res got);
            t_rot_res e;
            if (rotated_vectors.size() == 0) begin
                $error("result with no request outstanding: x=%0d y=%0d z=%0d err=%0b",
                       got.x, got.y, got.z, got.axis_err);
                n_errors++;
                return;
            end
            e = rotated_vectors.pop_front();
            n_checked++;
            if (got.x !== e.x) begin
                $error("out_x: expected %0d, got %0d", e.x, got.x);
                n_errors++;
            end
            if (got.y !== e.y) begin
                $error("out_y: expected %0d, got %0d", e.y, got.y);
                n_errors++;
            end
            if (got.z !== e.z) begin
                $error("out_z: expected %0d, got %0d", e.z, got.z);
                n_errors++;
            end
            if (got.axis_err !== e.axis_err) begin
                $error("axis_error: expected %0b, got %0b", e.axis_err, got.axis_err);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_vec_x = '0;
    logic signed [15:0] i_vec_y = '0;
    logic signed [15:0] i_vec_z = '0;
    logic [7:0]         i_axis_char = '0;
    logic signed [15:0] i_angle_deg = '0;
    logic               o_valid;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic signed [15:0] o_out_z;
    logic               o_axis_error;

    rotation_checker    sb = new();
    int                 n_cycles = 0;
    int                 n_sent = 0;

    axis_vector_rotator_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_axis_char  (i_axis_char),
        .i_angle_deg  (i_angle_deg),
        .o_valid      (o_valid),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_axis_error (o_axis_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("[axis_vector_rotator_top] ERROR");
            $finish;
        end
    end

    // results are taken at the edge that ends their valid cycle
    always @(posedge i_clk) begin
        t_rot_res got;
        if (i_rst_n && o_valid) begin
            got.x = o_out_x;
            got.y = o_out_y;
            got.z = o_out_z;
            got.axis_err = o_axis_error;
            sb.check_result(got);
        end
    end

    function automatic t_rot_req make_req(int vx, int vy, int vz, logic [7:0] axis, int ang);
        t_rot_req r;
        r.vx = 16'(vx);
        r.vy = 16'(vy);
        r.vz = 16'(vz);
        r.axis = axis;
        r.angle = 16'(ang);
        return r;
    endfunction

    function automatic logic signed [15:0] random_component();
        int sel;
        sel = $urandom_range(19);
        if (sel < 14) return 16'($urandom);
        if (sel < 17) begin
            case ($urandom_range(3))
                0: return 16'sd32767;
                1: return -16'sd32768;
                2: return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        return 16'($urandom_range(1024) - 512);
    endfunction

    function automatic t_rot_req random_request();
        t_rot_req   r;
        logic [7:0] letters[6];
        letters = '{CH_X_LO, CH_X_UP, CH_Y_LO, CH_Y_UP, CH_Z_LO, CH_Z_UP};
        r.vx = random_component();
        r.vy = random_component();
        r.vz = random_component();
        if ($urandom_range(99) < 80) r.axis = letters[$urandom_range(5)];
        else r.axis = 8'($urandom_range(255));
        case ($urandom_range(9))
            0, 1, 2, 3: r.angle = 16'($urandom);
            4, 5, 6:    r.angle = 16'(int'($urandom_range(46080)) - 23040);
            // land on and around the quadrant boundaries
            7:          r.angle = 16'((int'($urandom_range(8)) - 4) * 5760
                                      + int'($urandom_range(4)) - 2);
            8:          r.angle = 16'(int'($urandom_range(256)) - 128);
            default:    r.angle = 16'((int'($urandom_range(16)) - 8) * 2880);
        endcase
        return r;
    endfunction

    task automatic drive_fields(input t_rot_req r);
        i_vec_x     <= r.vx;
        i_vec_y     <= r.vy;
        i_vec_z     <= r.vz;
        i_axis_char <= r.axis;
        i_angle_deg <= r.angle;
    endtask

    task automatic send_request(input t_rot_req r, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            drive_fields(random_request());
            @(posedge i_clk);
        end
        start <= 1'b1;
        drive_fields(r);
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(r);
        n_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.rotated_vectors.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    initial begin
        t_rot_req directed[$];
        int       idle_pct;

        directed.push_back(make_req(256, 512, 768, CH_X_LO, 0));
        directed.push_back(make_req(256, 512, 768, CH_X_UP, 5760));
        directed.push_back(make_req(256, 512, 768, CH_Y_LO, 5760));
        directed.push_back(make_req(256, 512, 768, CH_Y_UP, -5760));
        directed.push_back(make_req(256, 512, 768, CH_Z_LO, 11520));
        directed.push_back(make_req(256, 512, 768, CH_Z_UP, 17280));
        // saturation at both bounds
        directed.push_back(make_req(32767, 32767, 32767, CH_Z_LO, 2880));
        directed.push_back(make_req(-32768, -32768, -32768, CH_X_LO, 2880));
        directed.push_back(make_req(-32768, 32767, -32768, CH_Y_LO, 11520));
        // full turn and angles past one turn
        directed.push_back(make_req(1000, -1000, 500, CH_Z_LO, 23040));
        directed.push_back(make_req(1000, -1000, 500, CH_Z_UP, -23040));
        directed.push_back(make_req(1000, -1000, 500, CH_X_UP, 32767));
        directed.push_back(make_req(1000, -1000, 500, CH_Y_LO, -32768));
        // letters that are not an axis pass the vector through
        directed.push_back(make_req(-32768, 32767, 0, 8'h00, 1234));
        directed.push_back(make_req(32767, -32768, -1, 8'hFF, -1234));
        directed.push_back(make_req(100, 200, 300, 8'h77, 5760));
        directed.push_back(make_req(100, 200, 300, 8'h7B, 5760));
        directed.push_back(make_req(100, 200, 300, 8'h5B, 5760));
        // either side of the fold at minus and plus ninety degrees
        directed.push_back(make_req(4096, -4096, 4096, CH_Z_LO, -5761));
        directed.push_back(make_req(4096, -4096, 4096, CH_Z_LO, 5759));
        directed.push_back(make_req(0, 0, 0, CH_X_LO, 1));
        directed.push_back(make_req(32767, -32768, 32767, CH_Z_UP, -1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_request(directed[i], 36);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 36 : (phase == 1) ? 54 : 0;
            for (int i = 0; i < N_RANDOM / 3; i++) send_request(random_request(), idle_pct);
            // hold off until the pipeline has emptied
            if (phase != 2) drain_results();
        end

        drain_results();
        if (sb.rotated_vectors.size() != 0) begin
            $error("%0d results never arrived", sb.rotated_vectors.size());
            sb.n_errors++;
        end

        $display("Rotated %0d vectors (%0d directed, %0d with a non-axis letter);",
                 n_sent, directed.size(), sb.n_bad_axis);
        $display("%0d results checked under three idling patterns, %0d mismatches.",
                 sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("[axis_vector_rotator_top] OK");
        end else begin
            $display("[axis_vector_rotator_top] ERROR");
        end
        $finish;
    end

endmodule
